// ===== design/pfac_pkg.sv =====
// Shared types and constants for the performance / frequency converter.
`timescale 1ns / 1ps

package pfac_pkg;

   // Operation codes carried in the request.
   localparam logic [1:0] OP_PERF_TO_KHZ = 2'd0;
   localparam logic [1:0] OP_SET_TARGET  = 2'd1;
   localparam logic [1:0] OP_RATE        = 2'd2;
   localparam logic [1:0] OP_PARK        = 2'd3;

   // Register indexes on the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWEST_FREQ  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_NOMINAL_FREQ = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOWEST_PERF  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_NOMINAL_PERF = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_HIGHEST_PERF = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_FALLBACK_MAX = 3'd5;

   localparam logic [25:0] FALLBACK_MAX_RESET = 26'd1000;

   // One request transfer.
   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] value;
      logic [63:0] ref_count_t0;
      logic [63:0] ref_count_t1;
      logic [63:0] deliv_count_t0;
      logic [63:0] deliv_count_t1;
      logic [31:0] reference_rate;
   } req_type;

   // One response transfer.
   typedef struct packed {
      logic [31:0] result_value;
      logic        changed;
      logic        div_fault;
   } rsp_type;

   // Command to the serial multiply-divide unit: (mcand * mplier) / divisor.
   typedef struct packed {
      logic        start;
      logic [63:0] mcand;
      logic [31:0] mplier;
      logic [63:0] divisor;
   } mdu_req_type;

   // Status returned by the multiply-divide unit.
   typedef struct packed {
      logic        busy;
      logic        done;
      logic [63:0] quotient;
   } mdu_sts_type;

endpackage

// ===== design/pfac_muldiv.sv =====
// Bit-serial multiply (wrapping at 64 bits) followed by a restoring divide.
`timescale 1ns / 1ps

module pfac_muldiv (
   input  logic                 clock,
   input  logic                 reset,
   input  pfac_pkg::mdu_req_type mdu_req,
   output pfac_pkg::mdu_sts_type mdu_sts
);

   typedef enum logic [2:0] {
      U_IDLE = 3'b001,
      U_MUL  = 3'b010,
      U_DIV  = 3'b100
   } ustate_type;

   ustate_type  ustate_ff, ustate_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] mcand_ff, mcand_in;
   logic [31:0] mplier_ff, mplier_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] div_ff, div_in;
   logic        done_ff, done_in;
   logic [64:0] trial;
   logic        fits;

   // One partial remainder step of the divide.
   assign trial = {rem_ff, acc_ff[63]};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      ustate_in = ustate_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      done_in   = 1'b0;
      case (ustate_ff)
         U_IDLE: begin
            if (mdu_req.start) begin
               mcand_in  = mdu_req.mcand;
               mplier_in = mdu_req.mplier;
               div_in    = mdu_req.divisor;
               acc_in    = '0;
               cnt_in    = '0;
               ustate_in = U_MUL;
            end
         end
         U_MUL: begin
            // Add the shifted multiplicand for each set multiplier bit.
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = {mcand_ff[62:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[31:1]};
            cnt_in    = cnt_ff + 6'd1;
            if (cnt_ff == 6'd31) begin
               cnt_in    = '0;
               rem_in    = '0;
               ustate_in = U_DIV;
            end
         end
         U_DIV: begin
            // The product shifts out at the top while quotient bits enter below.
            rem_in = fits ? 64'(trial - {1'b0, div_ff}) : trial[63:0];
            acc_in = {acc_ff[62:0], fits};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               done_in   = 1'b1;
               ustate_in = U_IDLE;
            end
         end
         default: begin
            ustate_in = U_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ustate_ff <= U_IDLE;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         ustate_ff <= ustate_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
   end

   assign mdu_sts.busy     = (ustate_ff != U_IDLE);
   assign mdu_sts.done     = done_ff;
   assign mdu_sts.quotient = acc_ff;

endmodule

// ===== design/perf_freq_affine_converter.sv =====
// Top level of the performance level / kHz converter with its sequencer.
`timescale 1ns / 1ps

// The block takes one request at a time and answers each with one response.
// All arithmetic runs through a single shared multiply-divide unit that
// performs a shift-add multiply followed by a restoring divide. A
// conversion (ops 0 and 1) takes one pass in the fallback map and two in
// the affine map; a rate estimate adds one more pass when the reference
// delta is non-zero. A zero divisor ends the conversion at once with a
// zero result and the fault flag. A new request may be taken while the
// previous response waits for transfer.
module perf_freq_affine_converter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pfac_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pfac_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [pfac_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RATE = 6'b000010,
      S_CONV = 6'b000100,
      S_OFFS = 6'b001000,
      S_MAIN = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] x_ff, x_in;
   logic [63:0] off_ff, off_in;
   logic [31:0] res_ff, res_in;
   logic        fault_ff, fault_in;
   logic [31:0] desired_ff, desired_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pfac_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] lowest_freq_ff, nominal_freq_ff;
   logic [31:0] lowest_perf_ff, nominal_perf_ff, highest_perf_ff;
   logic [25:0] fallback_max_ff;

   pfac_pkg::mdu_req_type mdu_req;
   pfac_pkg::mdu_sts_type mdu_sts;

   logic        accept;
   logic [63:0] dref, ddel;
   logic        affine, to_perf;
   logic [31:0] dif_freq, dif_perf;
   logic [31:0] mul_sel, div_sel, base_x, base_y;
   logic [63:0] sum;
   logic        rsp_free;

   // Configuration registers, always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         lowest_freq_ff  <= '0;
         nominal_freq_ff <= '0;
         lowest_perf_ff  <= '0;
         nominal_perf_ff <= '0;
         highest_perf_ff <= '0;
         fallback_max_ff <= pfac_pkg::FALLBACK_MAX_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            pfac_pkg::REG_LOWEST_FREQ:  lowest_freq_ff  <= csr_wdata;
            pfac_pkg::REG_NOMINAL_FREQ: nominal_freq_ff <= csr_wdata;
            pfac_pkg::REG_LOWEST_PERF:  lowest_perf_ff  <= csr_wdata;
            pfac_pkg::REG_NOMINAL_PERF: nominal_perf_ff <= csr_wdata;
            pfac_pkg::REG_HIGHEST_PERF: highest_perf_ff <= csr_wdata;
            pfac_pkg::REG_FALLBACK_MAX: fallback_max_ff <= csr_wdata[25:0];
            default: begin
            end
         endcase
      end
   end

   // Wrap-aware counter deltas.
   assign dref = ((req_data.ref_count_t1 > req_data.ref_count_t0) ||
                  (req_data.ref_count_t0[63:32] != 32'd0))
                 ? (req_data.ref_count_t1 - req_data.ref_count_t0)
                 : {32'd0, req_data.ref_count_t1[31:0] - req_data.ref_count_t0[31:0]};
   assign ddel = ((req_data.deliv_count_t1 > req_data.deliv_count_t0) ||
                  (req_data.deliv_count_t0[63:32] != 32'd0))
                 ? (req_data.deliv_count_t1 - req_data.deliv_count_t0)
                 : {32'd0, req_data.deliv_count_t1[31:0] - req_data.deliv_count_t0[31:0]};

   // Map selection: affine through two points or the line through the origin.
   assign affine   = (lowest_freq_ff != 32'd0) && (nominal_freq_ff != 32'd0);
   assign to_perf  = (op_ff == pfac_pkg::OP_SET_TARGET);
   assign dif_freq = nominal_freq_ff - lowest_freq_ff;
   assign dif_perf = nominal_perf_ff - lowest_perf_ff;

   always_comb begin
      if (affine) begin
         mul_sel = to_perf ? dif_perf : dif_freq;
         div_sel = to_perf ? dif_freq : dif_perf;
      end else begin
         mul_sel = to_perf ? highest_perf_ff : {6'd0, fallback_max_ff};
         div_sel = to_perf ? {6'd0, fallback_max_ff} : highest_perf_ff;
      end
      base_x = to_perf ? nominal_freq_ff : nominal_perf_ff;
      base_y = to_perf ? nominal_perf_ff : nominal_freq_ff;
   end

   assign sum      = off_ff + mdu_sts.quotient;
   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      x_in           = x_ff;
      off_in         = off_ff;
      res_in         = res_ff;
      fault_in       = fault_ff;
      desired_in     = desired_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      mdu_req.start   = 1'b0;
      mdu_req.mcand   = {32'd0, x_ff};
      mdu_req.mplier  = mul_sel;
      mdu_req.divisor = {32'd0, div_sel};
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_data.op;
               x_in     = req_data.value;
               fault_in = 1'b0;
               case (req_data.op)
                  pfac_pkg::OP_PARK: begin
                     res_in   = lowest_perf_ff;
                     state_in = S_DONE;
                  end
                  pfac_pkg::OP_RATE: begin
                     if (dref != 64'd0) begin
                        mdu_req.start   = 1'b1;
                        mdu_req.mcand   = ddel;
                        mdu_req.mplier  = req_data.reference_rate;
                        mdu_req.divisor = dref;
                        state_in        = S_RATE;
                     end else begin
                        x_in     = desired_ff;
                        state_in = S_CONV;
                     end
                  end
                  default: begin
                     state_in = S_CONV;
                  end
               endcase
            end
         end
         S_RATE: begin
            if (mdu_sts.done) begin
               x_in     = mdu_sts.quotient[31:0];
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            if (div_sel == 32'd0) begin
               fault_in = 1'b1;
               res_in   = '0;
               state_in = S_DONE;
            end else if (affine) begin
               mdu_req.start = 1'b1;
               mdu_req.mcand = {32'd0, base_x};
               state_in      = S_OFFS;
            end else begin
               mdu_req.start = 1'b1;
               off_in        = '0;
               state_in      = S_MAIN;
            end
         end
         S_OFFS: begin
            // Offset of the affine line, then the main term for the operand.
            if (mdu_sts.done) begin
               off_in        = {32'd0, base_y} - mdu_sts.quotient;
               mdu_req.start = 1'b1;
               state_in      = S_MAIN;
            end
         end
         S_MAIN: begin
            if (mdu_sts.done) begin
               res_in   = sum[63] ? 32'd0 : sum[31:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // Load the response register once it is free.
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.result_value = res_ff;
               rsp_data_in.div_fault    = fault_ff;
               rsp_data_in.changed      = 1'b0;
               if ((op_ff == pfac_pkg::OP_SET_TARGET) || (op_ff == pfac_pkg::OP_PARK)) begin
                  rsp_data_in.changed = (res_ff != desired_ff);
                  desired_in          = res_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         desired_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         desired_ff   <= desired_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      x_ff        <= x_in;
      off_ff      <= off_in;
      res_ff      <= res_in;
      fault_ff    <= fault_in;
      rsp_data_ff <= rsp_data_in;
   end

   pfac_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .mdu_req (mdu_req),
      .mdu_sts (mdu_sts)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The shared unit is only started while it is idle.
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      mdu_req.start |-> !mdu_sts.busy)
      else $error("multiply-divide unit started while busy");

   // A finished pass is only reported while the sequencer waits for one.
   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      mdu_sts.done |-> ((state_ff == S_RATE) || (state_ff == S_OFFS) ||
                        (state_ff == S_MAIN)))
      else $error("unexpected completion from multiply-divide unit");

   // A divisor fault always carries a zero result.
   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.div_fault) |-> (rsp_data.result_value == 32'd0))
      else $error("fault response with non-zero result");

endmodule

// ===== tb/tb_perf_freq_affine_converter.sv =====
// Self-checking testbench for the performance level / kHz converter.
`timescale 1ns / 1ps

module tb_perf_freq_affine_converter;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pfac_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pfac_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [pfac_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   perf_freq_affine_converter dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the registers and the stored desired level.
   logic [31:0] lo_freq, nom_freq, lo_perf, nom_perf, hi_perf, fb_max, desired;

   pfac_pkg::req_type pending_reqs[$];
   pfac_pkg::rsp_type expected_rsps[$];
   int unsigned mismatches = 0;
   int unsigned cycles = 0;
   int unsigned rsp_count = 0;
   int unsigned rate_count = 0;
   bit quiet = 1'b0;   // no idling during this stretch
   bit req_fire = 1'b0;   // a request transfer took place at the last rising edge

   // offset + x*mul/div, clamped at zero when negative.
   function automatic logic [31:0] affine(input logic [31:0] x, input logic [63:0] mul,
                                          input logic [63:0] div, input logic [63:0] offs,
                                          inout logic fault);
      logic [63:0] prod, sum;
      if (div == 0) begin
         fault = 1'b1;
         return '0;
      end
      prod = {32'd0, x} * mul;
      sum = offs + prod / div;
      return sum[63] ? 32'd0 : sum[31:0];
   endfunction

   // Converts a level to kHz (to_khz) or kHz to a level.
   function automatic logic [31:0] convert(input logic [31:0] x, input bit to_khz,
                                           inout logic fault);
      logic [31:0] m32, d32, anchor_in, anchor_out;
      logic [63:0] prod, offs;
      if (lo_freq != 0 && nom_freq != 0) begin
         m32 = to_khz ? nom_freq - lo_freq : nom_perf - lo_perf;
         d32 = to_khz ? nom_perf - lo_perf : nom_freq - lo_freq;
         anchor_in = to_khz ? nom_perf : nom_freq;
         anchor_out = to_khz ? nom_freq : nom_perf;
         if (d32 == 0) begin
            fault = 1'b1;
            return '0;
         end
         prod = {32'd0, anchor_in} * {32'd0, m32};
         offs = {32'd0, anchor_out} - prod / {32'd0, d32};
         return affine(x, {32'd0, m32}, {32'd0, d32}, offs, fault);
      end
      if (to_khz) return affine(x, {32'd0, fb_max}, {32'd0, hi_perf}, 64'd0, fault);
      return affine(x, {32'd0, hi_perf}, {32'd0, fb_max}, 64'd0, fault);
   endfunction

   // Wrap-aware difference of two counter snapshots.
   function automatic logic [63:0] count_delta(input logic [63:0] t1, input logic [63:0] t0);
      logic [31:0] d;
      if (t1 > t0 || t0 > 64'hFFFF_FFFF) return t1 - t0;
      d = t1[31:0] - t0[31:0];
      return {32'd0, d};
   endfunction

   // Works out the response for one request and updates the desired level.
   function automatic pfac_pkg::rsp_type predict_response(input pfac_pkg::req_type r);
      pfac_pkg::rsp_type o;
      logic fault;
      logic [63:0] dref, ddel, prod;
      logic [31:0] lvl;
      fault = 1'b0;
      o = '0;
      case (r.op)
         pfac_pkg::OP_PERF_TO_KHZ: o.result_value = convert(r.value, 1'b1, fault);
         pfac_pkg::OP_SET_TARGET: begin
            o.result_value = convert(r.value, 1'b0, fault);
            o.changed = o.result_value != desired;
            desired = o.result_value;
         end
         pfac_pkg::OP_RATE: begin
            dref = count_delta(r.ref_count_t1, r.ref_count_t0);
            ddel = count_delta(r.deliv_count_t1, r.deliv_count_t0);
            if (dref != 0) begin
               prod = {32'd0, r.reference_rate} * ddel;
               prod = prod / dref;
               lvl = prod[31:0];
            end else begin
               lvl = desired;
            end
            o.result_value = convert(lvl, 1'b1, fault);
         end
         default: begin
            o.result_value = lo_perf;
            o.changed = lo_perf != desired;
            desired = lo_perf;
         end
      endcase
      o.div_fault = fault;
      return o;
   endfunction

   // Request driver: changes at the falling edge, holds until the transfer.
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_fire) begin
            if (pending_reqs.size() != 0 && (quiet || $urandom_range(99) >= 14)) begin
               req_data <= pending_reqs.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= quiet || $urandom_range(99) >= 14;
      end
   end

   // Request and response monitor, sampled at the rising edge.
   always @(posedge clock) begin
      cycles++;
      req_fire = !reset && req_valid && req_ready;
      if (req_fire) begin
         expected_rsps.push_back(predict_response(req_data));
         if (req_data.op == pfac_pkg::OP_RATE) rate_count++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected response %h", rsp_data);
         end else begin
            if (rsp_data !== expected_rsps[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"Response mismatch: expected val=%h chg=%b flt=%b, ",
                            "got val=%h chg=%b flt=%b"},
                           expected_rsps[0].result_value, expected_rsps[0].changed,
                           expected_rsps[0].div_fault, rsp_data.result_value,
                           rsp_data.changed, rsp_data.div_fault);
            end
            void'(expected_rsps.pop_front());
         end
      end
      if (cycles > 1500000) begin
         $display("Timeout after %0d cycles", cycles);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Writes one register through the configuration port and mirrors it.
   task automatic write_reg(input logic [pfac_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] val);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         pfac_pkg::REG_LOWEST_FREQ: lo_freq = val;
         pfac_pkg::REG_NOMINAL_FREQ: nom_freq = val;
         pfac_pkg::REG_LOWEST_PERF: lo_perf = val;
         pfac_pkg::REG_NOMINAL_PERF: nom_perf = val;
         pfac_pkg::REG_HIGHEST_PERF: hi_perf = val;
         pfac_pkg::REG_FALLBACK_MAX: fb_max = {6'd0, val[25:0]};
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic write_all(input logic [31:0] lf, input logic [31:0] nf,
                            input logic [31:0] lp, input logic [31:0] np,
                            input logic [31:0] hp, input logic [31:0] fm);
      write_reg(pfac_pkg::REG_LOWEST_FREQ, lf);
      write_reg(pfac_pkg::REG_NOMINAL_FREQ, nf);
      write_reg(pfac_pkg::REG_LOWEST_PERF, lp);
      write_reg(pfac_pkg::REG_NOMINAL_PERF, np);
      write_reg(pfac_pkg::REG_HIGHEST_PERF, hp);
      write_reg(pfac_pkg::REG_FALLBACK_MAX, fm);
   endtask

   // Waits until every queued request is answered, then lets the block settle.
   task automatic drain();
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Counter snapshot: a 32-bit value, a full 64-bit value, a small value up to 4000 or one a little past 32 bits.
   function automatic logic [63:0] snapshot();
      case ($urandom_range(3))
         0: return {32'd0, $urandom};
         1: return rand64();
         2: return {32'd0, 32'd0} | $urandom_range(4000);
         default: return {$urandom_range(3), $urandom};
      endcase
   endfunction

   function automatic pfac_pkg::req_type random_req(input logic [1:0] op);
      pfac_pkg::req_type r;
      r.op = op;
      r.value = $urandom_range(1) ? $urandom : $urandom_range(70000);
      r.ref_count_t0 = snapshot();
      r.ref_count_t1 = $urandom_range(9) == 0 ? r.ref_count_t0
                       : ($urandom_range(1) ? r.ref_count_t0 + $urandom_range(100000)
                                             : snapshot());
      r.deliv_count_t0 = snapshot();
      r.deliv_count_t1 = $urandom_range(1) ? r.deliv_count_t0 + $urandom_range(200000)
                                            : snapshot();
      r.reference_rate = $urandom_range(1) ? $urandom : $urandom_range(500);
      return r;
   endfunction

   task automatic random_block(input int n);
      for (int i = 0; i < n; i++) pending_reqs.push_back(random_req($urandom_range(3)));
   endtask

   // Stimulus: directed cases, then random phases across several settings.
   initial begin
      pfac_pkg::req_type r;
      lo_freq = 0; nom_freq = 0; lo_perf = 0; nom_perf = 0; hi_perf = 0;
      fb_max = {6'd0, pfac_pkg::FALLBACK_MAX_RESET}; desired = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values: fallback map; the zero highest level makes level-to-kHz conversions fault.
      r = '0;
      r.op = pfac_pkg::OP_PERF_TO_KHZ; r.value = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_SET_TARGET; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_PARK; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_RATE; pending_reqs.push_back(r);
      drain();

      // Fallback map with extreme registers; zero fallback maximum faults.
      write_all(0, 0, 0, 0, 32'hFFFF_FFFF, 26'h3FF_FFFF);
      r = '0;
      r.op = pfac_pkg::OP_PERF_TO_KHZ; r.value = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_SET_TARGET; r.value = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_SET_TARGET; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_RATE; r.ref_count_t0 = 64'hFFFF_FFF0; r.ref_count_t1 = 64'h10;
      r.deliv_count_t0 = '1; r.deliv_count_t1 = 0; r.reference_rate = '1;
      pending_reqs.push_back(r);
      drain();
      write_reg(pfac_pkg::REG_FALLBACK_MAX, 0);
      r = '0; r.op = pfac_pkg::OP_SET_TARGET; r.value = 1234; pending_reqs.push_back(r);
      drain();

      // Affine map with equal levels (zero divisor) and an inverted line.
      write_all(800000, 2000000, 20, 20, 40, 3000000);
      r = '0; r.op = pfac_pkg::OP_PERF_TO_KHZ; r.value = 30; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_SET_TARGET; r.value = 1000000; pending_reqs.push_back(r);
      drain();
      write_all(2000000, 800000, 10, 30, 40, 3000000);
      r = '0; r.op = pfac_pkg::OP_PERF_TO_KHZ; r.value = 0; pending_reqs.push_back(r);
      r.value = 32'hFFFF_FFFF; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_PARK; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_PARK; pending_reqs.push_back(r);
      r.op = pfac_pkg::OP_RATE; r.ref_count_t0 = 5; r.ref_count_t1 = 5;
      pending_reqs.push_back(r);
      drain();

      // Random phases over a mix of plausible and extreme register settings.
      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 4)
            0: write_all(0, $urandom_range(1) ? 0 : $urandom, $urandom_range(100),
                         $urandom_range(300), $urandom_range(1000),
                         $urandom_range(65535000, 1000));
            1: write_all($urandom_range(1200000, 400000), $urandom_range(3500000, 1300000),
                         $urandom_range(50), $urandom_range(300, 60), $urandom_range(400),
                         $urandom_range(65535000, 1000));
            2: write_all($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            default: write_all(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1000);
         endcase
         quiet = (ph == 5);
         random_block(100);
         drain();
      end
      quiet = 1'b0;

      $display("Covered %0d responses, %0d rate estimates, over 17 register settings.",
               rsp_count, rate_count);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/pfac_pkg.sv
design/pfac_muldiv.sv
design/perf_freq_affine_converter.sv
tb/tb_perf_freq_affine_converter.sv
